@@ hw/rtl/hrsa_pkg.sv @@
// Shared types and constants of the heart rate session averager.
`default_nettype none

package hrsa_pkg;

    // Item and result payloads
    typedef struct packed {
        logic [31:0] time_ms;
        logic        card_seen;
        logic        beat_seen;
    } t_in_item;

    typedef struct packed {
        logic       in_session;
        logic       beat_accepted;
        logic [7:0] current_rate;
        logic       session_done;
        logic [7:0] session_rate;
    } t_out_item;

    // Configuration register map
    localparam int unsigned CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SESSION_LEN = 2'd0,
        CFG_WARMUP      = 2'd1
    } t_cfg_idx;

    localparam logic [31:0] SESSION_LEN_RST = 32'd60000;
    localparam logic [31:0] WARMUP_RST      = 32'd30000;

    // Beat interval window and rate arithmetic
    localparam int unsigned INTERVAL_W   = 12;
    localparam logic [31:0] INTERVAL_MIN = 32'd236;
    localparam logic [31:0] INTERVAL_MAX = 32'd2999;

    localparam int unsigned RATE_W      = 8;
    localparam int unsigned SUM_W       = 16;
    localparam int unsigned COUNT_W     = 8;
    localparam int unsigned DIVIDEND_W  = 16;
    localparam int unsigned DIVISOR_W   = 12;

    localparam logic [DIVIDEND_W-1:0] RATE_NUMERATOR = 16'd60000;
    localparam logic [COUNT_W-1:0]    COUNT_MAX      = 8'd255;

    // Front-to-back command queue
    localparam int unsigned CMD_DEPTH = 2;

    typedef struct packed {
        logic                  open_session;
        logic                  beat_ok;
        logic                  warm;
        logic                  close;
        logic                  in_session;
        logic [INTERVAL_W-1:0] interval;
    } t_cmd;

endpackage

`default_nettype wire

@@ hw/rtl/heart_rate_session_averager_unit.sv @@
// Heart rate session averager top level: front, command queue and back.
// A tick is classified by the front, queued and then executed by the back; an accepted beat
// adds the serial rate divide and the ring mean, and a close with a nonzero beat count adds
// the session divide. The front takes new ticks while the back is busy, until the queue,
// which holds two classified ticks, is full.
// Reset (synchronous, active low) ends any session, clears ring and sums, loads defaults.
`default_nettype none

module heart_rate_session_averager_unit #(
    parameter int unsigned RING_SLOTS = 4
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire hrsa_pkg::t_in_item             i_item,
    output logic                                empty,
    input  wire logic                           pop,
    output hrsa_pkg::t_out_item                 o_item,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [hrsa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                    i_cfg_data
);

    logic           q_full;
    logic           q_push;
    hrsa_pkg::t_cmd q_in;
    logic           q_pop;
    hrsa_pkg::t_cmd q_out;
    logic           q_avail;
    logic           res_valid;

    hrsa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .i_q_full    (q_full),
        .o_cmd_push  (q_push),
        .o_cmd       (q_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    hrsa_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_avail (q_avail)
    );

    hrsa_back #(
        .RING_SLOTS (RING_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_avail (q_avail),
        .i_cmd       (q_out),
        .o_cmd_pop   (q_pop),
        .o_res_valid (res_valid),
        .o_res       (o_item),
        .i_res_pop   (pop)
    );

    assign full        = q_full;
    assign empty       = !res_valid;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

@@ hw/rtl/hrsa_div.sv @@
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module hrsa_div (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic [hrsa_pkg::DIVIDEND_W-1:0]     i_dividend,
    input  wire logic [hrsa_pkg::DIVISOR_W-1:0]      i_divisor,
    output logic                                     o_done,
    output logic [hrsa_pkg::DIVIDEND_W-1:0]          o_quotient
);

    localparam int unsigned NW    = hrsa_pkg::DIVIDEND_W;
    localparam int unsigned DW    = hrsa_pkg::DIVISOR_W;
    localparam int unsigned CNT_W = $clog2(NW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW:0]      r_rem;
    logic [NW-1:0]    r_quo;
    logic [DW-1:0]    r_dvs;

    logic [DW:0]      shifted;
    logic             fits;

    assign shifted = {r_rem[DW-1:0], r_quo[NW-1]};
    assign fits    = (shifted >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? (shifted - {1'b0, r_dvs}) : shifted;
            r_quo <= {r_quo[NW-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

@@ hw/rtl/hrsa_cmd_fifo.sv @@
// Short command queue between the classifying front and the executing back.
`default_nettype none

module hrsa_cmd_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire hrsa_pkg::t_cmd i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output hrsa_pkg::t_cmd     o_data,
    output logic               o_avail
);

    localparam int unsigned DEPTH = hrsa_pkg::CMD_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    hrsa_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_avail = (r_cnt != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_avail;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/hrsa_front.sv @@
// Front: takes ticks, tracks session timing and classifies each tick into a command.
`default_nettype none

module hrsa_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire hrsa_pkg::t_in_item            i_item,
    input  wire logic                          i_q_full,
    output logic                               o_cmd_push,
    output hrsa_pkg::t_cmd                     o_cmd,
    input  wire logic                          i_cfg_valid,
    input  wire logic [hrsa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                   i_cfg_data
);

    logic        r_active;
    logic [31:0] r_start;
    logic [31:0] r_last;
    logic [31:0] r_session_len;
    logic [31:0] r_warmup;

    logic        accept;
    logic [31:0] elapsed;
    logic [31:0] interval;
    logic        n_active;
    hrsa_pkg::t_cmd cmd;

    assign accept   = i_push && !i_q_full;
    assign elapsed  = i_item.time_ms - r_start;
    assign interval = i_item.time_ms - r_last;

    always_comb begin
        n_active         = r_active;
        cmd.open_session = 1'b0;
        cmd.beat_ok      = 1'b0;
        cmd.close        = 1'b0;
        cmd.warm         = (elapsed > r_warmup);
        cmd.interval     = interval[hrsa_pkg::INTERVAL_W-1:0];
        if (!r_active) begin
            // the opening tick handles no beat and cannot close
            if (i_item.card_seen) begin
                n_active         = 1'b1;
                cmd.open_session = 1'b1;
            end
        end else begin
            cmd.beat_ok = i_item.beat_seen
                          && (interval >= hrsa_pkg::INTERVAL_MIN)
                          && (interval <= hrsa_pkg::INTERVAL_MAX);
            if (elapsed > r_session_len) begin
                n_active  = 1'b0;
                cmd.close = 1'b1;
            end
        end
        cmd.in_session = n_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= 1'b0;
            r_start       <= '0;
            r_last        <= '0;
            r_session_len <= hrsa_pkg::SESSION_LEN_RST;
            r_warmup      <= hrsa_pkg::WARMUP_RST;
        end else begin
            if (accept) begin
                r_active <= n_active;
                if (!r_active && i_item.card_seen) begin
                    r_start <= i_item.time_ms;
                end
                // a running session records every beat, in range or not
                if (r_active && i_item.beat_seen) begin
                    r_last <= i_item.time_ms;
                end
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    hrsa_pkg::CFG_SESSION_LEN: r_session_len <= i_cfg_data;
                    hrsa_pkg::CFG_WARMUP:      r_warmup      <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign o_cmd_push = accept;
    assign o_cmd      = cmd;

endmodule

`default_nettype wire

@@ hw/rtl/hrsa_back.sv @@
// Back: runs the rate division, rate ring, session sum and close report per command.
`default_nettype none

module hrsa_back #(
    parameter int unsigned RING_SLOTS = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cmd_avail,
    input  wire hrsa_pkg::t_cmd i_cmd,
    output logic                o_cmd_pop,
    output logic                o_res_valid,
    output hrsa_pkg::t_out_item o_res,
    input  wire logic           i_res_pop
);

    localparam int unsigned RW      = hrsa_pkg::RATE_W;
    localparam int unsigned SW      = hrsa_pkg::SUM_W;
    localparam int unsigned CW      = hrsa_pkg::COUNT_W;
    localparam int unsigned NW      = hrsa_pkg::DIVIDEND_W;
    localparam int unsigned DW      = hrsa_pkg::DIVISOR_W;
    localparam int unsigned SLOT_W  = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam int unsigned TOTAL_W = $clog2(RING_SLOTS * 255 + 1);

    // ring mean by reciprocal multiply, exact for every ring total
    localparam int unsigned     MEAN_SHIFT = 24;
    localparam int unsigned     MUL_W      = MEAN_SHIFT + 1;
    localparam int unsigned     PROD_W     = TOTAL_W + MUL_W;
    localparam longint unsigned MEAN_MUL_L =
        ((64'd1 << MEAN_SHIFT) + 64'(RING_SLOTS) - 64'd1) / 64'(RING_SLOTS);
    localparam logic [MUL_W-1:0] MEAN_MUL  = MUL_W'(MEAN_MUL_L);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b000_0001,
        ST_DEC  = 7'b000_0010,
        ST_RDIV = 7'b000_0100,
        ST_RING = 7'b000_1000,
        ST_CLS  = 7'b001_0000,
        ST_CDIV = 7'b010_0000,
        ST_OUT  = 7'b100_0000
    } t_state;

    t_state              r_state, n_state;
    hrsa_pkg::t_cmd      r_cmd;
    logic [RW-1:0]       r_ring [RING_SLOTS];
    logic [TOTAL_W-1:0]  r_total;
    logic [SLOT_W-1:0]   r_slot;
    logic [RW-1:0]       r_mean;
    logic [SW-1:0]       r_sum;
    logic [CW-1:0]       r_count;
    logic                r_accepted;
    logic [RW-1:0]       r_report;
    logic                r_res_valid;
    hrsa_pkg::t_out_item r_res;

    logic              div_start;
    logic [NW-1:0]     div_dividend;
    logic [DW-1:0]     div_divisor;
    logic              div_done;
    logic [NW-1:0]     div_q;
    logic              res_take;
    logic              res_load;
    logic [PROD_W-1:0] mean_prod;
    logic [RW-1:0]     mean_new;

    hrsa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign res_take  = i_res_pop && r_res_valid;
    assign res_load  = (r_state == ST_OUT) && (!r_res_valid || res_take);
    assign o_cmd_pop = (r_state == ST_IDLE) && i_cmd_avail;

    assign mean_prod = PROD_W'(r_total) * PROD_W'(MEAN_MUL);
    assign mean_new  = mean_prod[MEAN_SHIFT +: RW];

    always_comb begin
        n_state      = r_state;
        div_start    = 1'b0;
        div_dividend = hrsa_pkg::RATE_NUMERATOR;
        div_divisor  = r_cmd.interval;
        unique case (r_state)
            ST_IDLE: if (i_cmd_avail) n_state = ST_DEC;
            ST_DEC: begin
                if (r_cmd.beat_ok) begin
                    div_start = 1'b1;
                    n_state   = ST_RDIV;
                end else begin
                    n_state = ST_CLS;
                end
            end
            ST_RDIV: if (div_done) n_state = ST_RING;
            ST_RING: n_state = ST_CLS;
            ST_CLS: begin
                div_dividend = r_sum;
                div_divisor  = DW'(r_count);
                if (r_cmd.close && (r_count != '0)) begin
                    div_start = 1'b1;
                    n_state   = ST_CDIV;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_CDIV: if (div_done) n_state = ST_OUT;
            ST_OUT:  if (res_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_res_valid <= 1'b0;
            r_total     <= '0;
            r_slot      <= '0;
            r_mean      <= '0;
            r_sum       <= '0;
            r_count     <= '0;
            for (int i = 0; i < RING_SLOTS; i++) begin
                r_ring[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (res_load) begin
                r_res_valid <= 1'b1;
            end else if (res_take) begin
                r_res_valid <= 1'b0;
            end
            if (o_cmd_pop && i_cmd.open_session) begin
                r_sum   <= '0;
                r_count <= '0;
            end
            if ((r_state == ST_RDIV) && div_done) begin
                // keep a running total so the mean needs no adder tree
                r_ring[r_slot] <= div_q[RW-1:0];
                r_total <= r_total - TOTAL_W'(r_ring[r_slot]) + TOTAL_W'(div_q[RW-1:0]);
                r_slot  <= (r_slot == SLOT_W'(RING_SLOTS - 1)) ? '0 : r_slot + 1'b1;
            end
            if (r_state == ST_RING) begin
                r_mean <= mean_new;
                if (r_cmd.warm && (r_count != hrsa_pkg::COUNT_MAX)) begin
                    r_sum   <= r_sum + SW'(mean_new);
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd      <= i_cmd;
            r_accepted <= 1'b0;
        end
        if ((r_state == ST_RDIV) && div_done) begin
            r_accepted <= 1'b1;
        end
        if (r_state == ST_CLS) begin
            r_report <= '0;
        end
        if ((r_state == ST_CDIV) && div_done) begin
            r_report <= div_q[RW-1:0];
        end
        if (res_load) begin
            r_res.in_session    <= r_cmd.in_session;
            r_res.beat_accepted <= r_accepted;
            r_res.current_rate  <= r_mean;
            r_res.session_done  <= r_cmd.close;
            r_res.session_rate  <= r_report;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

@@ hw/rtl/hrsa_checker.sv @@
// Port-level checks for the heart rate session averager, bound to the top level.
`default_nettype none

module hrsa_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                empty,
    input wire logic                pop,
    input wire hrsa_pkg::t_out_item o_item
);

    // a stalled transaction holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_item)))
        else $error("result changed while stalled");

    a_report_only_on_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_item.session_done) |-> (o_item.session_rate == 8'd0))
        else $error("session rate reported outside a close");

    a_close_ends_session: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_item.session_done) |-> !o_item.in_session)
        else $error("session still running on its closing transaction");

    a_beat_needs_session: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_item.beat_accepted) |-> (o_item.in_session || o_item.session_done))
        else $error("beat accepted outside a session");

    a_rate_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_item.current_rate != 8'd255) && (o_item.session_rate != 8'd255)))
        else $error("rate out of range");

endmodule

bind heart_rate_session_averager_unit hrsa_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .empty   (empty),
    .pop     (pop),
    .o_item  (o_item)
);

`default_nettype wire
